@@ hw/rtl/smoothed_block_average_assert.svh @@
// Assertion macros for the smoothed block average RTL.
// No dependencies; include with the bare file name.
`ifndef SMOOTHED_BLOCK_AVERAGE_ASSERT_SVH
`define SMOOTHED_BLOCK_AVERAGE_ASSERT_SVH

// Checked property, muted while reset is high.
`define SBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define SBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sba_pkg.sv @@
// Shared constants for the smoothed block average.
// No dependencies.
package sba_pkg;

  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration port
  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH = 2'd1;

  localparam logic [REG_BITS-1:0] ALPHA_RESET  = 16'd6554;
  localparam logic [REG_BITS-1:0] LENGTH_RESET = 16'd2000;

endpackage

@@ hw/rtl/sba_sample_if.sv @@
// Sample input channel: valid/ready plus one converter reading.
// Depends on sba_pkg for the default width.
interface sba_sample_if #(
  parameter int SAMPLE_BITS = sba_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

@@ hw/rtl/sba_mean_if.sv @@
// Result channel: valid/ready plus one block mean.
// Depends on sba_pkg for the default width.
interface sba_mean_if #(
  parameter int SAMPLE_BITS = sba_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] block_mean;

  modport source (output valid, output block_mean, input ready);
  modport sink   (input valid, input block_mean, output ready);
endinterface

@@ hw/rtl/sba_addsub.sv @@
// Shared add/subtract unit of the smoothed block average.
// No dependencies.
module sba_addsub #(
  parameter int WIDTH = 30
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] result
);

  // two's complement: a + ~b + 1 when subtracting
  assign result = a + (sub ? ~b : b) + {{(WIDTH-1){1'b0}}, sub};

endmodule

@@ hw/rtl/smoothed_block_average.sv @@
// Smoothed block average: first-order smoothing filter, one rounded mean per block.
// Per sample: accept, setup, one add per alpha bit, filter and sum updates, not ready meanwhile;
//   a block's last sample adds the rounding step, the serial divide and the output load.
// The mean is registered once the divide ends, later while the previous mean waits.
//   Uses sba_pkg, sba_*_if, sba_addsub, the assert header.
// Sync active-high reset clears filter, count, sum and output valid; alpha = 6554, length = 2000.
`include "smoothed_block_average_assert.svh"

module smoothed_block_average #(
  parameter int SAMPLE_BITS   = sba_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = sba_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sba_pkg::REG_BITS-1:0]       cfg_data,
  sba_sample_if.sink                         sample,
  sba_mean_if.source                         mean
);

  localparam int S       = SAMPLE_BITS;
  localparam int F       = FRACTION_BITS;
  localparam int CW      = sba_pkg::REG_BITS;
  localparam int ALPHA_W = (F < CW) ? F : CW;   // alpha is masked to Q0.F
  localparam int FVW     = S + F;               // filter value QS.F
  localparam int SUMW    = FVW + CW;            // up to 65535 filter values
  localparam int W       = SUMW + 2;            // adder width, signed headroom
  localparam int MAXSTEP = (F > S) ? F : S;
  localparam int STEPW   = $clog2(MAXSTEP + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;  // d = fv - sample*2^F
  localparam logic [2:0] ST_FILT  = 3'd2;  // serial alpha*d, LSB first
  localparam logic [2:0] ST_NEWFV = 3'd3;  // fv = sample*2^F + floor(alpha*d/2^F)
  localparam logic [2:0] ST_ACCUM = 3'd4;  // sum += fv, block end check
  localparam logic [2:0] ST_ROUND = 3'd5;  // sum + count*2^(F-1)
  localparam logic [2:0] ST_DIV   = 3'd6;  // restoring divide by count
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]         state;
  logic [ALPHA_W-1:0] alpha;
  logic [CW-1:0]      block_length;

  logic [FVW-1:0]  fv;
  logic [SUMW-1:0] sum;
  logic [CW-1:0]   count;
  logic [S-1:0]    sample_reg;
  logic [F-1:0]    keep_sr;
  logic [W-1:0]    d_reg;
  logic [W-1:0]    acc;
  logic [STEPW-1:0] step;
  logic [CW-1:0]   div_c;
  logic [CW:0]     rem;
  logic [S-1:0]    nq;       // dividend low bits shifting out, quotient shifting in
  logic            mean_valid;
  logic [S-1:0]    mean_data;

  logic [W-1:0] alu_a;
  logic [W-1:0] alu_b;
  logic         alu_sub;
  logic [W-1:0] alu_res;

  logic         accept;
  logic         emit_load;
  logic         blk_end;
  logic [CW:0]  trial;

  // No transaction is taken while reset is held
  assign sample.ready = (state == ST_IDLE) && !rst;
  assign accept       = sample.valid && sample.ready;
  assign mean.valid   = mean_valid;
  assign mean.block_mean = mean_data;

  // Output register frees up when empty or being taken this cycle
  assign emit_load = (state == ST_EMIT) && (!mean_valid || mean.ready);

  // count already includes this sample; a zero count is treated as a block end
  assign blk_end = (count == '0) || (count >= block_length);

  // Next partial remainder: remainder shifted left with the next dividend bit in
  assign trial = {rem[CW-1:0], nq[S-1]};

  // ---------------------------------------------------------------
  // Operand selection for the shared adder
  // ---------------------------------------------------------------
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_PREP: begin
        alu_a   = W'(fv);
        alu_b   = W'(sample_reg) << F;
        alu_sub = 1'b1;
      end
      ST_FILT: begin
        alu_a = acc;
        alu_b = keep_sr[0] ? d_reg : '0;
      end
      ST_NEWFV: begin
        alu_a = W'(sample_reg) << F;
        alu_b = acc;
      end
      ST_ACCUM: begin
        alu_a = W'(sum);
        alu_b = W'(fv);
      end
      ST_ROUND: begin
        alu_a = W'(sum);
        alu_b = W'(div_c) << (F - 1);
      end
      ST_DIV: begin
        alu_a   = W'(trial);
        alu_b   = W'(div_c);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  sba_addsub #(
    .WIDTH(W)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res)
  );

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= ALPHA_W'(sba_pkg::ALPHA_RESET);
      block_length <= sba_pkg::LENGTH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == sba_pkg::REG_ALPHA) begin
        alpha <= cfg_data[ALPHA_W-1:0];
      end else if (cfg_index == sba_pkg::REG_LENGTH) begin
        block_length <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequencer and filter/sum state
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fv    <= '0;
      sum   <= '0;
      count <= '0;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count + 1'b1;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          step  <= '0;
          state <= ST_FILT;
        end
        ST_FILT: begin
          step <= step + 1'b1;
          if (step == STEPW'(F - 1)) begin
            state <= ST_NEWFV;
          end
        end
        ST_NEWFV: begin
          fv    <= alu_res[FVW-1:0];
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          sum   <= alu_res[SUMW-1:0];
          state <= blk_end ? ST_ROUND : ST_IDLE;
        end
        ST_ROUND: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEPW'(S - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // block restart: filter, count and sum back to zero
          if (emit_load) begin
            fv    <= '0;
            sum   <= '0;
            count <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          sample_reg <= sample.sample_value;
          keep_sr    <= F'(alpha);
        end
      end
      ST_PREP: begin
        d_reg <= alu_res;
        acc   <= '0;
      end
      ST_FILT: begin
        // floor((acc + bit*d)/2), arithmetic shift keeps the floor exact
        acc     <= {alu_res[W-1], alu_res[W-1:1]};
        keep_sr <= keep_sr >> 1;
      end
      ST_ACCUM: begin
        div_c <= (count == '0) ? CW'(1) : count;
      end
      ST_ROUND: begin
        // N = floor((sum + c*2^(F-1)) / 2^F); N >> S is below c
        nq  <= alu_res[F+S-1:F];
        rem <= alu_res[F+S+CW:F+S];
      end
      ST_DIV: begin
        if (!alu_res[W-1]) begin
          rem <= alu_res[CW:0];
        end else begin
          rem <= trial;
        end
        nq <= {nq[S-2:0], ~alu_res[W-1]};
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (emit_load) begin
      mean_valid <= 1'b1;
    end else if (mean.ready) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      mean_data <= nq;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `SBA_ASSERT(a_accept_starts, accept |=> (state == ST_PREP), "accepted sample did not start")
  `SBA_ASSERT(a_filt_steps, (state == ST_FILT) |-> (step < STEPW'(F)), "filter step overrun")
  `SBA_ASSERT(a_rem_below, (state == ST_DIV) |-> (rem < {1'b0, div_c}), "remainder not below count")
  `SBA_ASSERT(a_restart, emit_load |=> ((count == '0) && (sum == '0) && (fv == '0)), "block restart")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for smoothed_block_average: directed table, then random sample traffic.
// Depends on sba_pkg, sba_sample_if, sba_mean_if and the smoothed_block_average RTL.
// Block means are checked against a cycle-free fixed-point model of the smoothing filter.
module tb_top;

  localparam int SAMPLE_W = sba_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W   = sba_pkg::FRACTION_BITS_DEF;
  localparam int REG_W    = sba_pkg::REG_BITS;
  localparam int IDX_W    = sba_pkg::CFG_INDEX_BITS;
  localparam int FILT_W   = SAMPLE_W + FRAC_W;
  localparam int SUM_W    = FILT_W + REG_W;

  // Worst case per sample: serial multiply plus the end-of-block divide, with some margin.
  localparam int SETTLE_CYCLES = (FRAC_W + 3) + (SAMPLE_W + 2) + 8;
  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  // Register indexes the block does not decode; writes there must be ignored.
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  // One row of the directed table. For a sample row, value holds the sample; typed marks a
  // row whose block mean is written into the table by hand instead of taken from the model.
  typedef struct packed {
    row_kind_t           kind;
    logic [IDX_W-1:0]    index;
    logic [REG_W-1:0]    value;
    logic                typed;
    logic [SAMPLE_W-1:0] mean;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  sba_sample_if sample_ch ();
  sba_mean_if   mean_ch ();

  smoothed_block_average DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .mean      (mean_ch)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter model: its own copy of the registers and of the block state.
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0]  alpha_q;
  logic [REG_W-1:0]  length_q;
  logic [FILT_W-1:0] filt_q;
  logic [REG_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;

  logic [SAMPLE_W-1:0] expected_means [$];
  int                  mismatch_count = 0;

  // Handshake-free side channel from the stimulus to the checker for hand-typed rows.
  bit                  typed_on = 1'b0;
  logic [SAMPLE_W-1:0] typed_mean = '0;

  // Idle percentages of the current phase.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_count = 0;

  // Takes one sample into the filter; reports whether it closes the block and the block mean.
  function automatic void filter_sample(input logic [SAMPLE_W-1:0] s, output bit closed,
                                        output logic [SAMPLE_W-1:0] mean_out);
    logic [63:0] take;
    logic [63:0] kept;
    logic [63:0] divisor;
    // new = (1 - alpha) * sample + alpha * old, the second product truncated
    take    = (64'd1 << FRAC_W) - 64'(alpha_q);
    kept    = (64'(alpha_q) * 64'(filt_q)) >> FRAC_W;
    filt_q  = FILT_W'(take * 64'(s) + kept);
    sum_q   = sum_q + SUM_W'(filt_q);
    count_q = count_q + 1'b1;
    // A length of zero acts like one; a length lowered below the count ends at once.
    closed   = (count_q == '0) || (count_q >= length_q);
    mean_out = '0;
    if (closed) begin
      divisor = 64'(count_q) << FRAC_W;
      if (divisor == 64'd0) begin
        divisor = 64'd1 << FRAC_W;
      end
      // round half up of sum / count
      mean_out = SAMPLE_W'((64'(sum_q) + (divisor >> 1)) / divisor);
      filt_q   = '0;
      sum_q    = '0;
      count_q  = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checker. Everything is sampled at the rising edge; the block's outputs only
  // change after it, and the testbench drives on the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit                  closed;
    logic [SAMPLE_W-1:0] mean_pred;
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      alpha_q  = sba_pkg::ALPHA_RESET;
      length_q = sba_pkg::LENGTH_RESET;
      filt_q   = '0;
      count_q  = '0;
      sum_q    = '0;
      expected_means.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sba_pkg::REG_ALPHA:  alpha_q = cfg_data;
          sba_pkg::REG_LENGTH: length_q = cfg_data;
          default: begin
          end
        endcase
      end
      // Predict before checking, so a mean due in this cycle finds its expectation queued.
      if (sample_ch.valid && sample_ch.ready) begin
        filter_sample(sample_ch.sample_value, closed, mean_pred);
        if (typed_on) begin
          expected_means.push_back(typed_mean);
        end else if (closed) begin
          expected_means.push_back(mean_pred);
        end
      end
      if (mean_ch.valid && mean_ch.ready) begin
        if (expected_means.size() == 0) begin
          $error("block_mean: unexpected transaction, expected none, actual %0d",
                 mean_ch.block_mean);
          mismatch_count++;
        end else begin
          want = expected_means.pop_front();
          if (mean_ch.block_mean !== want) begin
            $error("block_mean: expected %0d, actual %0d", want, mean_ch.block_mean);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || cfg_write || (sample_ch.valid && sample_ch.ready) ||
        (mean_ch.valid && mean_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: stalls at random per the current phase.
  initial begin
    mean_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      mean_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic plan_row_t cfg_row(logic [IDX_W-1:0] idx, logic [REG_W-1:0] v);
    return '{kind: ROW_CONFIG, index: idx, value: v, typed: 1'b0, mean: '0};
  endfunction

  function automatic plan_row_t sample_row(int unsigned v);
    return '{kind: ROW_SAMPLE, index: sba_pkg::REG_ALPHA, value: REG_W'(v), typed: 1'b0,
             mean: '0};
  endfunction

  function automatic plan_row_t checked_row(int unsigned v, int unsigned m);
    return '{kind: ROW_SAMPLE, index: sba_pkg::REG_ALPHA, value: REG_W'(v), typed: 1'b1,
             mean: SAMPLE_W'(m)};
  endfunction

  // Mostly uniform, with the range ends now and then.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_alpha();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return sba_pkg::ALPHA_RESET;
      default: return REG_W'($urandom_range(65535));
    endcase
  endfunction

  // Register writes go in only once the block is quiet: no mean outstanding, and long
  // enough for a sample that closes nothing to finish its update.
  task automatic write_register(logic [IDX_W-1:0] idx, logic [REG_W-1:0] v);
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_means.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One sample transaction, with a random gap in front when the phase asks for one.
  // valid stays high after the handshake; the next falling edge either lowers it or
  // presents the next sample, never both.
  task automatic send_sample(logic [SAMPLE_W-1:0] v, bit typed = 1'b0,
                             logic [SAMPLE_W-1:0] want = '0);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
    @(negedge clk);
    typed_on   = typed;
    typed_mean = want;
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= v;
    do @(posedge clk); while (!sample_ch.ready);
    sent_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   plan [$];
    int unsigned phase_end;
    int unsigned blk;
    int unsigned cut;

    cfg_write              = 1'b0;
    cfg_index              = sba_pkg::REG_ALPHA;
    cfg_data               = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    plan = '{
      // Reset values: a few samples under the reset length close nothing, then a
      // shorter length ends the running block on the next sample.
      sample_row(4095), sample_row(0), sample_row(2048),
      cfg_row(sba_pkg::REG_LENGTH, 16'd2), sample_row(1),
      // Alpha of zero passes each sample straight through.
      cfg_row(sba_pkg::REG_ALPHA, 16'd0), cfg_row(sba_pkg::REG_LENGTH, 16'd1),
      checked_row(0, 0), checked_row(4095, 4095),
      checked_row(2730, 2730), checked_row(1365, 1365),
      // Length zero behaves as length one.
      cfg_row(sba_pkg::REG_LENGTH, 16'd0), checked_row(100, 100),
      // Two-sample blocks: the mean lands on a half and rounds up.
      cfg_row(sba_pkg::REG_LENGTH, 16'd2), sample_row(1), checked_row(2, 2),
      sample_row(4095), checked_row(4094, 4095),
      // Largest alpha keeps almost nothing of the sample.
      cfg_row(sba_pkg::REG_ALPHA, 16'hFFFF), cfg_row(sba_pkg::REG_LENGTH, 16'd1),
      checked_row(4095, 0),
      // Longest block, cut short by a lower length; alpha changed mid-block too.
      cfg_row(sba_pkg::REG_LENGTH, 16'hFFFF), sample_row(4095), sample_row(4095),
      sample_row(4095),
      cfg_row(sba_pkg::REG_ALPHA, 16'd32768), cfg_row(sba_pkg::REG_LENGTH, 16'd3),
      sample_row(2000),
      // Writes to undecoded indexes leave both registers alone.
      cfg_row(sba_pkg::REG_ALPHA, 16'd0), cfg_row(sba_pkg::REG_LENGTH, 16'd1),
      cfg_row(REG_SPARE_A, 16'hFFFF), cfg_row(REG_SPARE_B, 16'hFFFF), checked_row(77, 77)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        write_register(plan[i].index, plan[i].value);
      end else begin
        send_sample(plan[i].value[SAMPLE_W-1:0], plan[i].typed, plan[i].mean);
      end
    end

    // Random part, in four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 54;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 54;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      phase_end = sent_count + 125;
      while (sent_count < phase_end) begin
        if ($urandom_range(1) != 0) begin
          write_register(sba_pkg::REG_ALPHA, rand_alpha());
        end
        if ($urandom_range(7) != 0) begin
          // Well-formed block: set a short length and fill it exactly.
          blk = ($urandom_range(15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          write_register(sba_pkg::REG_LENGTH, REG_W'(blk));
          repeat (blk) send_sample(rand_sample());
        end else begin
          // Broken block: settings change partway, then a length of one realigns.
          blk = $urandom_range(4, 12);
          write_register(sba_pkg::REG_LENGTH, REG_W'(blk));
          cut = $urandom_range(1, blk - 1);
          repeat (cut) send_sample(rand_sample());
          if ($urandom_range(1) != 0) begin
            write_register(sba_pkg::REG_ALPHA, rand_alpha());
          end
          write_register(sba_pkg::REG_LENGTH, REG_W'($urandom_range(0, blk)));
          repeat ($urandom_range(1, 3)) send_sample(rand_sample());
          write_register(sba_pkg::REG_LENGTH, 16'd1);
          send_sample(rand_sample());
        end
      end
    end

    // Drain: drop valid, wait for every mean, then let the block settle.
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_means.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
